FILE: src/cni_pkg.sv
package cni_pkg;

  localparam int MaxNodes   = 8;
  localparam int SlotW      = 3;
  localparam int CountW     = 4;
  localparam int FracOne    = 65536;
  localparam int AddrW      = 4;

  // configuration register byte addresses
  localparam logic [AddrW-1:0] RegNodeCount = 4'h0;
  localparam logic [AddrW-1:0] RegEndA      = 4'h4;
  localparam logic [AddrW-1:0] RegEndB      = 4'h8;

  localparam logic OpEval = 1'b0;
  localparam logic OpLoad = 1'b1;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatSeg  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_CHK, S_SCAN, S_SUB, S_MUL1, S_DIV2, S_FIX2,
    S_MUL2, S_ENDS, S_ENDS2, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        busy;
  } seq_ctl_t;

endpackage

FILE: src/cni_if.sv
interface cni_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] count_a;
  logic [15:0] count_b;
  logic [2:0]  node_slot;
  logic [16:0] node_position;
  logic signed [31:0] node_value;
  modport source (output valid, operation, count_a, count_b, node_slot, node_position,
                  node_value, input ready);
  modport sink (input valid, operation, count_a, count_b, node_slot, node_position,
                node_value, output ready);
endinterface

interface cni_out_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] energy;
  logic [1:0]  status;
  modport source (output valid, energy, status, input ready);
  modport sink (input valid, energy, status, output ready);
endinterface

FILE: src/cni_serial_div.sv
// Restoring divider, one quotient bit per cycle, unsigned 48/32.
module cni_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  cni_pkg::seq_ctl_t ctl,
  input  logic [47:0]       dividend,
  input  logic [31:0]       divisor,
  output logic [47:0]       quotient,
  output logic              done
);
  logic [47:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quo[47]};
  assign trial   = shifted - {1'b0, dvs};

  // shift one dividend bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= 6'd48;
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (run) begin
        if (!trial[32]) begin
          rem <= trial;
        end else begin
          rem <= shifted;
        end
        quo <= {quo[46:0], ~trial[32]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (!rst && ctl.start) begin
      assert (!run) else $error("divider restarted while busy");
    end
  end
endmodule

FILE: src/cni_serial_mul.sv
// Shift-add multiplier: 34-bit magnitude by 32-bit magnitude, one bit per cycle.
module cni_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  cni_pkg::seq_ctl_t ctl,
  input  logic [33:0]       mcand,
  input  logic [31:0]       mplier,
  output logic [65:0]       product,
  output logic              done
);
  logic [65:0] acc;
  logic [33:0] mc;
  logic [31:0] mp;
  logic [5:0]  cnt;
  logic        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= 6'd32;
        acc <= '0;
        mc  <= mcand;
        mp  <= mplier;
      end else if (run) begin
        // shift left, then add the multiplicand if the top multiplier bit is set
        acc <= {acc[64:0], 1'b0} + (mp[31] ? {32'd0, mc} : 66'd0);
        mp  <= {mp[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;
endmodule

FILE: src/composition_node_interpolator_core.sv
// Sequence: a load word is answered in the cycle after it is accepted; an
// evaluate word runs fraction divide, check, node scan, setup, multiply,
// segment divide, fixup, multiply, out. Pure-end or no-node evaluations run
// two multiplies; zero counts go straight to out, an empty segment after setup.
// Throughput: one word at a time; the next word is taken after the result leaves.
// Reset: rst synchronous; state and config/result regs clear to 0, table garbage.
module composition_node_interpolator_core (
  input  logic                 clk,
  input  logic                 rst,
  cni_in_if.sink               in_ch,
  cni_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [cni_pkg::AddrW-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  cni_pkg::state_t state, state_next;

  logic [3:0]         node_count;
  logic signed [31:0] end_a, end_b;
  logic [16:0]        pos_mem [cni_pkg::MaxNodes];
  logic signed [31:0] val_mem [cni_pkg::MaxNodes];

  logic [15:0] ca, cb;
  logic [16:0] total, frac;
  logic [16:0] xl, xr;
  logic signed [31:0] yl, yr;
  logic        have_lo, have_hi;
  logic [2:0]  idx;
  logic [3:0]  used;
  logic signed [63:0] v;
  logic signed [63:0] energy_r, acc_e;
  logic [1:0]  status_r;
  logic        out_valid;

  cni_pkg::seq_ctl_t div_ctl, mul_ctl;
  logic [47:0] div_a;
  logic [31:0] div_b;
  logic [47:0] div_q;
  logic        div_done;
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] mul_p;
  logic        mul_done;
  logic        mul_neg;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_valid && out_ch.ready;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      end_a <= '0;
      end_b <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        cni_pkg::RegNodeCount: node_count <= pwdata[3:0];
        cni_pkg::RegEndA:      end_a <= pwdata;
        cni_pkg::RegEndB:      end_b <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      cni_pkg::RegNodeCount: prdata = {28'd0, node_count};
      cni_pkg::RegEndA:      prdata = end_a;
      cni_pkg::RegEndB:      prdata = end_b;
      default:               prdata = '0;
    endcase
  end

  assign used = (node_count > 4'(cni_pkg::MaxNodes)) ? 4'(cni_pkg::MaxNodes) : node_count;

  // node table
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.operation == cni_pkg::OpLoad) begin
      pos_mem[in_ch.node_slot] <= in_ch.node_position;
      val_mem[in_ch.node_slot] <= in_ch.node_value;
    end
  end

  cni_serial_div u_div (.clk, .rst, .ctl(div_ctl), .dividend(div_a), .divisor(div_b),
                        .quotient(div_q), .done(div_done));
  cni_serial_mul u_mul (.clk, .rst, .ctl(mul_ctl), .mcand(mul_a), .mplier(mul_b),
                        .product(mul_p), .done(mul_done));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cni_pkg::S_IDLE:
        if (in_fire) begin
          if (in_ch.operation == cni_pkg::OpLoad) state_next = cni_pkg::S_OUT;
          else if (in_ch.count_a == 16'd0 && in_ch.count_b == 16'd0)
            state_next = cni_pkg::S_OUT;
          else state_next = cni_pkg::S_DIV1;
        end
      cni_pkg::S_DIV1: if (div_done) state_next = cni_pkg::S_CHK;
      cni_pkg::S_CHK:
        if (frac == 17'd0 || frac == 17'(cni_pkg::FracOne) || used == 4'd0)
          state_next = cni_pkg::S_ENDS;
        else state_next = cni_pkg::S_SCAN;
      cni_pkg::S_SCAN: if ({1'b0, idx} == used - 4'd1) state_next = cni_pkg::S_SUB;
      cni_pkg::S_SUB:  state_next = (xr <= xl) ? cni_pkg::S_OUT : cni_pkg::S_MUL1;
      cni_pkg::S_MUL1: if (mul_done) state_next = cni_pkg::S_DIV2;
      cni_pkg::S_DIV2: if (div_done) state_next = cni_pkg::S_FIX2;
      cni_pkg::S_FIX2: state_next = cni_pkg::S_MUL2;
      cni_pkg::S_MUL2: if (mul_done) state_next = cni_pkg::S_OUT;
      cni_pkg::S_ENDS: if (mul_done) state_next = cni_pkg::S_ENDS2;
      cni_pkg::S_ENDS2: if (mul_done) state_next = cni_pkg::S_OUT;
      cni_pkg::S_OUT:  if (out_fire) state_next = cni_pkg::S_IDLE;
      default: state_next = cni_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cni_pkg::S_IDLE;
    else state <= state_next;
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state == cni_pkg::S_IDLE);
    out_valid   = (state == cni_pkg::S_OUT);
    div_ctl.busy = (state == cni_pkg::S_DIV1) || (state == cni_pkg::S_DIV2);
    mul_ctl.busy = (state == cni_pkg::S_MUL1) || (state == cni_pkg::S_MUL2) ||
                   (state == cni_pkg::S_ENDS) || (state == cni_pkg::S_ENDS2);
    div_ctl.start = (state == cni_pkg::S_IDLE && in_fire &&
                     in_ch.operation == cni_pkg::OpEval &&
                     !(in_ch.count_a == 16'd0 && in_ch.count_b == 16'd0)) ||
                    (state == cni_pkg::S_MUL1 && mul_done);
    mul_ctl.start = (state == cni_pkg::S_SUB && !(xr <= xl)) ||
                    (state == cni_pkg::S_CHK && state_next == cni_pkg::S_ENDS) ||
                    (state == cni_pkg::S_FIX2) ||
                    (state == cni_pkg::S_ENDS && mul_done);
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.energy = energy_r;
  assign out_ch.status = status_r;

  wire [16:0] p_cur = pos_mem[idx];
  wire signed [32:0] dy = {yr[31], yr} - {yl[31], yl};
  wire [16:0] dx = frac - xl;
  wire [16:0] w  = xr - xl;
  wire signed [63:0] prod_s = mul_neg ? -$signed(mul_p[63:0]) : $signed(mul_p[63:0]);

  // operand muxing for the shared units
  always_comb begin
    div_a = '0; div_b = '0;
    if (state == cni_pkg::S_IDLE) begin
      div_a = {16'd0, in_ch.count_b, 16'd0};
      div_b = {15'd0, 17'({1'b0, in_ch.count_a} + {1'b0, in_ch.count_b})};
    end else begin
      // segment numerator straight from the multiplier as it finishes
      div_a = mul_p[47:0];
      div_b = {15'd0, w};
    end
    mul_a = '0; mul_b = '0;
    unique case (state)
      cni_pkg::S_SUB: begin
        mul_a = {17'd0, dx};
        mul_b = dy[32] ? 32'(-dy) : dy[31:0];
      end
      cni_pkg::S_FIX2: begin
        mul_a = v[63] ? 34'(-v) : v[33:0];
        mul_b = {15'd0, total};
      end
      cni_pkg::S_CHK: begin
        mul_a = end_a[31] ? 34'(-{{2{end_a[31]}}, end_a}) : {2'b0, end_a};
        mul_b = {16'd0, ca};
      end
      cni_pkg::S_ENDS: begin
        mul_a = end_b[31] ? 34'(-{{2{end_b[31]}}, end_b}) : {2'b0, end_b};
        mul_b = {16'd0, cb};
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_r <= '0;
      status_r <= cni_pkg::StatOk;
    end else begin
      unique case (state)
        cni_pkg::S_IDLE:
          if (in_fire) begin
            ca <= in_ch.count_a;
            cb <= in_ch.count_b;
            total <= {1'b0, in_ch.count_a} + {1'b0, in_ch.count_b};
            energy_r <= '0;
            status_r <= (in_ch.operation == cni_pkg::OpEval && in_ch.count_a == 16'd0 &&
                         in_ch.count_b == 16'd0) ? cni_pkg::StatZero : cni_pkg::StatOk;
          end
        cni_pkg::S_DIV1: if (div_done) frac <= div_q[16:0];
        cni_pkg::S_CHK: begin
          xl <= '0; xr <= 17'(cni_pkg::FracOne);
          yl <= end_a; yr <= end_b;
          have_lo <= 1'b0; have_hi <= 1'b0;
          idx <= '0;
          mul_neg <= end_a[31];
        end
        cni_pkg::S_SCAN: begin
          // one node per cycle
          if (p_cur < frac) begin
            if (!have_lo || p_cur >= xl) begin
              xl <= p_cur; yl <= val_mem[idx]; have_lo <= 1'b1;
            end
          end else if (!have_hi || p_cur < xr) begin
            xr <= p_cur; yr <= val_mem[idx]; have_hi <= 1'b1;
          end
          idx <= idx + 3'd1;
        end
        cni_pkg::S_SUB: begin
          if (xr <= xl) status_r <= cni_pkg::StatSeg;
          mul_neg <= dy[32];
        end
        cni_pkg::S_DIV2: if (div_done) begin
          v <= {{32{yl[31]}}, yl} + (mul_neg ? -$signed({16'd0, div_q}) :
                                                $signed({16'd0, div_q}));
        end
        cni_pkg::S_FIX2: mul_neg <= v[63];
        cni_pkg::S_MUL2: if (mul_done) energy_r <= prod_s;
        cni_pkg::S_ENDS: if (mul_done) begin
          acc_e <= prod_s; mul_neg <= end_b[31];
        end
        cni_pkg::S_ENDS2: if (mul_done) energy_r <= acc_e + prod_s;
        default: ;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_valid) else $error("ready while result pending");
  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(div_ctl.busy && mul_ctl.busy)) else $error("both units claimed");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(energy_r))
    else $error("result changed under stall");
endmodule
